### rtl/lrc_pkg.sv
// Package for the LRU replacement cache: port widths, defaults and the
// controller-to-datapath command type. No dependencies.

package lrc_pkg;

   // Fixed port widths
   localparam int REQ_KEY_W = 16;
   localparam int CAP_W     = 5;
   localparam int MISS_W    = 32;

   // Build defaults
   localparam int DEFAULT_WAYS     = 16;
   localparam int DEFAULT_KEY_BITS = 16;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the requested key
      logic match;   // compare the key against all ways, register the outcome
      logic update;  // apply hit or miss to the array and produce the result
   } lrc_cmd_type;

endpackage : lrc_pkg

### rtl/lrc_ctrl.sv
// Controller of the LRU replacement cache: sequences load, match and update.
// Depends on lrc_pkg.

module lrc_ctrl
   import lrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output lrc_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      match_ff;
   logic      update_ff;

   // Take an item when idle and asked to start
   assign busy       = busy_ff;
   assign cmd.load   = start && !busy_ff;
   assign cmd.match  = match_ff;
   assign cmd.update = update_ff;

   // Hold state and registered commands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         match_ff  <= 1'b0;
         update_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_MATCH;
                  busy_ff  <= 1'b1;
                  match_ff <= 1'b1;
               end
            end
            ST_MATCH: begin
               state_ff  <= ST_UPDATE;
               match_ff  <= 1'b0;
               update_ff <= 1'b1;
            end
            ST_UPDATE: begin
               state_ff  <= ST_IDLE;
               update_ff <= 1'b0;
               busy_ff   <= 1'b0;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               match_ff  <= 1'b0;
               update_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule : lrc_ctrl

### rtl/lrc_dpath.sv
// Datapath of the LRU replacement cache: key array, valid bits, recency ranks,
// fill count, miss counter, capacity register and result registers.
// Depends on lrc_pkg.

module lrc_dpath
   import lrc_pkg::*;
#(
   parameter int WAYS     = DEFAULT_WAYS,
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lrc_cmd_type          cmd,
   input  logic [REQ_KEY_W-1:0] req_request_key,
   input  logic                 csr_we,
   input  logic [CAP_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic                 rsp_evicted_valid,
   output logic [REQ_KEY_W-1:0] rsp_evicted_key,
   output logic [MISS_W-1:0]    rsp_miss_count
);

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int CMP_W  = ((FILL_W > CAP_W) ? FILL_W : CAP_W) + 1;

   // Clamp a capacity value into one to the number of ways
   function automatic logic [CMP_W-1:0] clamp_cap(input logic [CAP_W-1:0] cap);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(cap);
      if (ext == '0)
         return CMP_W'(1);
      else if (ext > CMP_W'(WAYS))
         return CMP_W'(WAYS);
      else
         return ext;
   endfunction

   // Array state
   logic [KEY_BITS-1:0] keys_ff [WAYS];
   logic [RANK_W-1:0]   rank_ff [WAYS];
   logic [WAYS-1:0]     valid_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [MISS_W-1:0]   miss_ff;
   logic [CAP_W-1:0]    cap_ff;

   // Item in flight and match outcome
   logic [KEY_BITS-1:0] key_ff;
   logic [WAYS-1:0]     hit_vec_ff;
   logic                any_hit_ff;
   logic [RANK_W-1:0]   hit_rank_ff;
   logic                full_ff;
   logic [WAYS-1:0]     victim_ff;
   logic [WAYS-1:0]     free_ff;

   // Result registers
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_ev_valid_ff;
   logic [REQ_KEY_W-1:0] rsp_ev_key_ff;

   // Match-stage combinational values
   logic [WAYS-1:0]     hit_vec_in;
   logic [RANK_W-1:0]   hit_rank_in;
   logic [WAYS-1:0]     victim_in;
   logic [WAYS-1:0]     free_in;
   logic                full_in;
   logic [RANK_W-1:0]   last_rank;

   // Update-stage combinational values
   logic [WAYS-1:0]     slot_vec;
   logic [KEY_BITS-1:0] ev_key;
   logic [MISS_W-1:0]   miss_in;

   // Compare the key against every way; find the oldest and lowest free way
   assign last_rank = RANK_W'(fill_ff - FILL_W'(1));
   assign full_in   = CMP_W'(fill_ff) >= clamp_cap(cap_ff);
   assign free_in   = ~valid_ff & (valid_ff + WAYS'(1));

   always_comb begin
      hit_rank_in = '0;
      for (int i = 0; i < WAYS; i++) begin
         hit_vec_in[i] = valid_ff[i] && (keys_ff[i] == key_ff);
         victim_in[i]  = valid_ff[i] && (rank_ff[i] == last_rank);
         if (hit_vec_in[i])
            hit_rank_in = hit_rank_in | rank_ff[i];
      end
   end

   // Pick the way to write and read out the evicted key
   assign slot_vec = any_hit_ff ? hit_vec_ff : (full_ff ? victim_ff : free_ff);

   always_comb begin
      ev_key = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (victim_ff[i])
            ev_key = ev_key | keys_ff[i];
      end
   end

   // Saturating miss count
   assign miss_in = (miss_ff == '1) ? miss_ff : miss_ff + MISS_W'(1);

   // Capture the item and the match outcome
   always_ff @(posedge clock) begin
      if (cmd.load)
         key_ff <= KEY_BITS'(req_request_key);
      if (cmd.match) begin
         hit_vec_ff  <= hit_vec_in;
         any_hit_ff  <= |hit_vec_in;
         hit_rank_ff <= hit_rank_in;
         full_ff     <= full_in;
         victim_ff   <= victim_in;
         free_ff     <= free_in;
      end
   end

   // Write keys into the chosen way on a miss
   always_ff @(posedge clock) begin
      for (int i = 0; i < WAYS; i++) begin
         if (cmd.update && !any_hit_ff && slot_vec[i])
            keys_ff[i] <= key_ff;
      end
   end

   // Advance valid bits, ranks, fill and misses; flush when the capacity drops below the fill
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         miss_ff  <= '0;
         cap_ff   <= CAP_RESET;
         for (int i = 0; i < WAYS; i++)
            rank_ff[i] <= '0;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
         if (clamp_cap(csr_wdata) < CMP_W'(fill_ff)) begin
            valid_ff <= '0;
            fill_ff  <= '0;
            for (int i = 0; i < WAYS; i++)
               rank_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         if (any_hit_ff) begin
            for (int i = 0; i < WAYS; i++) begin
               if (hit_vec_ff[i])
                  rank_ff[i] <= '0;
               else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff))
                  rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end else begin
            for (int i = 0; i < WAYS; i++) begin
               if (slot_vec[i]) begin
                  valid_ff[i] <= 1'b1;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i]) begin
                  rank_ff[i] <= rank_ff[i] + RANK_W'(1);
               end
            end
            if (!full_ff)
               fill_ff <= fill_ff + FILL_W'(1);
            miss_ff <= miss_in;
         end
      end
   end

   // Strobe the result for one cycle
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.update;
   end

   // Hold the result fields
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff      <= any_hit_ff;
         rsp_ev_valid_ff <= !any_hit_ff && full_ff;
         rsp_ev_key_ff   <= (!any_hit_ff && full_ff) ? REQ_KEY_W'(ev_key) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;
   assign rsp_miss_count    = miss_ff;

endmodule : lrc_dpath

### rtl/lru_replacement_cache.sv
// Fully associative key cache with least-recently-used replacement.
// The result strobe rsp_valid is registered from the update step, which follows the load and match steps.
// Items are taken one at a time (load key, parallel match, update), in the controller
// sequence; busy is high from the start edge until the update, and no new item is taken while busy.
// Reset (synchronous): all ways invalid, fill and miss count zero, capacity 16.
// Results cannot be stalled; each item's result is shown for one cycle.

module lru_replacement_cache
   import lrc_pkg::*;
#(
   parameter int WAYS     = DEFAULT_WAYS,
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [REQ_KEY_W-1:0] req_request_key,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic                 rsp_evicted_valid,
   output logic [REQ_KEY_W-1:0] rsp_evicted_key,
   output logic [MISS_W-1:0]    rsp_miss_count,
   input  logic                 csr_we,
   input  logic [CAP_W-1:0]     csr_wdata
);

   lrc_cmd_type cmd;

   // Sequence each item
   lrc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold the array and produce results
   lrc_dpath #(
      .WAYS     (WAYS),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_request_key   (req_request_key),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_miss_count    (rsp_miss_count)
   );

   // Finishing an item always shows its result
   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result strobe");

   // A hit leaves the miss count unchanged
   a_hit_keeps_misses: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid && rsp_hit |-> $stable(rsp_miss_count))
      else $error("miss count moved on a hit");

   // Work starts only when an item was offered
   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(busy) |-> $past(start))
      else $error("busy rose without start");

endmodule : lru_replacement_cache

### tb/lrc_lookup_checker.sv
// Checker for the LRU replacement cache: follows the request, result and
// capacity ports, predicts every lookup and compares. Depends on lrc_pkg.

module lrc_lookup_checker
   import lrc_pkg::*;
#(
   parameter int WAYS     = DEFAULT_WAYS,
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [REQ_KEY_W-1:0] req_request_key,
   input  logic                 csr_we,
   input  logic [CAP_W-1:0]     csr_wdata,
   input  logic                 rsp_valid,
   input  logic                 rsp_hit,
   input  logic                 rsp_evicted_valid,
   input  logic [REQ_KEY_W-1:0] rsp_evicted_key,
   input  logic [MISS_W-1:0]    rsp_miss_count,
   output int unsigned          fail_count,
   output int unsigned          pending_lookups,
   output int unsigned          lookups_seen,
   output int unsigned          hits_seen,
   output int unsigned          evictions_seen
);

   localparam logic [63:0] KEY_MASK_WIDE = (64'd1 << KEY_BITS) - 64'd1;
   localparam logic [REQ_KEY_W-1:0] KEY_MASK = KEY_MASK_WIDE[REQ_KEY_W-1:0];

   typedef struct {
      logic                 hit;
      logic                 evicted_valid;
      logic [REQ_KEY_W-1:0] evicted_key;
      logic [MISS_W-1:0]    miss_count;
   } lookup_result_type;

   // Shadow copy of the cache contents and the capacity register
   logic [REQ_KEY_W-1:0] way_key [WAYS];
   bit                   way_valid [WAYS];
   int unsigned          way_rank [WAYS];
   int unsigned          ways_filled;
   logic [MISS_W-1:0]    misses_total;
   logic [CAP_W-1:0]     capacity_reg;
   lookup_result_type    awaited_lookups [$];

   // Clamp the register into 1..WAYS
   function automatic int unsigned capacity_in_use();
      if (capacity_reg == '0)
         return 1;
      if (capacity_reg > WAYS)
         return WAYS;
      return 32'(capacity_reg);
   endfunction

   task automatic flush_ways();
      for (int i = 0; i < WAYS; i++) begin
         way_valid[i] = 1'b0;
         way_rank[i]  = 0;
      end
      ways_filled = 0;
   endtask

   // Apply one lookup to the shadow cache and return the result it gives
   function automatic lookup_result_type predict_lookup(input logic [REQ_KEY_W-1:0] raw_key);
      logic [REQ_KEY_W-1:0] key;
      int                   found;
      int                   slot;
      int unsigned          old_rank;
      lookup_result_type    r;
      key             = raw_key & KEY_MASK;
      found           = -1;
      slot            = -1;
      r.hit           = 1'b0;
      r.evicted_valid = 1'b0;
      r.evicted_key   = '0;
      for (int i = 0; i < WAYS; i++)
         if (found < 0 && way_valid[i] && way_key[i] == key)
            found = i;
      if (found >= 0) begin
         // hit: entries more recent than this one age by a step
         r.hit    = 1'b1;
         old_rank = way_rank[found];
         for (int i = 0; i < WAYS; i++)
            if (way_valid[i] && way_rank[i] < old_rank)
               way_rank[i]++;
         way_rank[found] = 0;
      end else begin
         // miss: when full drop the oldest entry, else fill the lowest free way
         if (ways_filled >= capacity_in_use())
            for (int i = 0; i < WAYS; i++)
               if (way_valid[i] && (slot < 0 || way_rank[i] > way_rank[slot]))
                  slot = i;
         if (slot >= 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_key   = way_key[slot];
            way_valid[slot] = 1'b0;
         end else begin
            for (int i = 0; i < WAYS; i++)
               if (slot < 0 && !way_valid[i])
                  slot = i;
            ways_filled++;
         end
         for (int i = 0; i < WAYS; i++)
            if (way_valid[i])
               way_rank[i]++;
         way_key[slot]   = key;
         way_valid[slot] = 1'b1;
         way_rank[slot]  = 0;
         if (misses_total != '1)
            misses_total++;
      end
      r.miss_count = misses_total;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [MISS_W-1:0] want,
                                input logic [MISS_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_ports
      lookup_result_type want;
      if (reset) begin
         flush_ways();
         misses_total   = '0;
         capacity_reg   = CAP_RESET;
         fail_count     = 0;
         lookups_seen   = 0;
         hits_seen      = 0;
         evictions_seen = 0;
         awaited_lookups.delete();
      end else begin
         // compare a result against the oldest prediction
         if (rsp_valid === 1'b1) begin
            if (awaited_lookups.size() == 0) begin
               fail_count++;
               $display("%0t: result with none awaited, hit %0b evicted %0b key %0h misses %0h",
                        $time, rsp_hit, rsp_evicted_valid, rsp_evicted_key, rsp_miss_count);
            end else begin
               want = awaited_lookups.pop_front();
               compare_field("hit", MISS_W'(want.hit), MISS_W'(rsp_hit));
               compare_field("evicted_valid", MISS_W'(want.evicted_valid),
                             MISS_W'(rsp_evicted_valid));
               compare_field("evicted_key", MISS_W'(want.evicted_key),
                             MISS_W'(rsp_evicted_key));
               compare_field("miss_count", want.miss_count, rsp_miss_count);
            end
         end
         // capacity write: shrinking below the fill flushes the cache
         if (csr_we === 1'b1) begin
            capacity_reg = csr_wdata;
            if (capacity_in_use() < ways_filled)
               flush_ways();
         end
         // accepted item: predict its result
         if (start === 1'b1 && busy === 1'b0) begin
            want = predict_lookup(req_request_key);
            awaited_lookups.push_back(want);
            lookups_seen++;
            if (want.hit)
               hits_seen++;
            if (want.evicted_valid)
               evictions_seen++;
         end
      end
      pending_lookups = awaited_lookups.size();
   end

endmodule : lrc_lookup_checker

### tb/tb_top.sv
// Top of the LRU replacement cache testbench: clock, reset, request and
// capacity stimulus, and the verdict. Depends on lrc_pkg and lrc_lookup_checker.

module tb_top;
   import lrc_pkg::*;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 140;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [REQ_KEY_W-1:0] req_request_key;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic                 rsp_evicted_valid;
   logic [REQ_KEY_W-1:0] rsp_evicted_key;
   logic [MISS_W-1:0]    rsp_miss_count;
   logic                 csr_we;
   logic [CAP_W-1:0]     csr_wdata;

   int unsigned fail_count;
   int unsigned pending_lookups;
   int unsigned lookups_seen;
   int unsigned hits_seen;
   int unsigned evictions_seen;

   lru_replacement_cache u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_request_key   (req_request_key),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_miss_count    (rsp_miss_count),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   lrc_lookup_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_request_key   (req_request_key),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_miss_count    (rsp_miss_count),
      .fail_count        (fail_count),
      .pending_lookups   (pending_lookups),
      .lookups_seen      (lookups_seen),
      .hits_seen         (hits_seen),
      .evictions_seen    (evictions_seen)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hold a key on the request ports until the block takes the item
   task automatic issue_key(input logic [REQ_KEY_W-1:0] key);
      @(negedge clock);
      start           <= 1'b1;
      req_request_key <= key;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start for a burst of cycles, with noise on the key
   task automatic pause_sender(input int unsigned cycles);
      @(negedge clock);
      start           <= 1'b0;
      req_request_key <= REQ_KEY_W'($urandom);
      repeat (cycles - 1) begin
         @(negedge clock);
         req_request_key <= REQ_KEY_W'($urandom);
      end
   endtask

   // Drop start and wait for every awaited result
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_lookups != 0)
         @(negedge clock);
   endtask

   // Write the capacity register with the block idle
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      logic [REQ_KEY_W-1:0] pool_base;
      logic [CAP_W-1:0]     cap_value;
      int unsigned          pool_size;
      int unsigned          cap_used;
      int unsigned          gap_pct;
      int unsigned          settings_run;
      reset           = 1'b1;
      start           = 1'b0;
      req_request_key = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      settings_run    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extreme keys, then hits on two of them
      issue_key(16'h0000);
      issue_key(16'hFFFF);
      issue_key(16'hAAAA);
      issue_key(16'h5555);
      issue_key(16'h0000);
      issue_key(16'hFFFF);

      // Shrink below the fill: flush, then evict round a hit
      set_capacity(5'd2);
      issue_key(16'h0001);
      issue_key(16'h0002);
      issue_key(16'h0003);
      issue_key(16'h0002);
      issue_key(16'h0004);

      // Zero acts as one entry
      set_capacity(5'd0);
      issue_key(16'h0007);
      issue_key(16'h0007);
      issue_key(16'h0008);

      // Above the way count clamps to full size; contents stay
      set_capacity(5'd31);
      issue_key(16'h0008);

      // Grow past the fill: contents stay
      set_capacity(5'd3);
      issue_key(16'h0009);
      issue_key(16'h0008);
      settings_run = 5;

      // Random phases: keys mostly from a pool larger than the capacity, by up to the capacity plus two
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:          cap_value = 5'd1;
            1:          cap_value = 5'd16;
            2:          cap_value = 5'd0;
            3:          cap_value = 5'd31;
            PHASES - 1: cap_value = 5'd16;
            default:    cap_value = CAP_W'($urandom_range(0, 31));
         endcase
         set_capacity(cap_value);
         settings_run++;
         cap_used  = (cap_value == 0) ? 1 :
                     (cap_value > DEFAULT_WAYS) ? DEFAULT_WAYS : cap_value;
         pool_base = REQ_KEY_W'($urandom);
         pool_size = cap_used + $urandom_range(1, cap_used + 2);
         gap_pct   = (p == 4 || p == PHASES - 1) ? 0 : $urandom_range(5, 35);
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 88)
               issue_key(REQ_KEY_W'(pool_base + $urandom_range(0, pool_size - 1)));
            else
               issue_key(REQ_KEY_W'($urandom));
            if ($urandom_range(0, 99) < gap_pct)
               pause_sender($urandom_range(1, 15));
            else if (gap_pct != 0 && $urandom_range(0, 199) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d lookups: %0d hits, %0d misses, %0d evictions,",
               lookups_seen, hits_seen, lookups_seen - hits_seen, evictions_seen);
      $display("over %0d capacity settings with flushes, clamping and idle gaps.",
               settings_run);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule : tb_top
